// File: rtl/core/plcm_pkg.sv
// Shared types and codes for the piecewise-linear color map.
// No dependencies; the top level imports this package.
`default_nettype none
package plcm_pkg;

  localparam int KIND_W = 3;
  localparam int CFG_INDEX_W = 2;

  typedef enum logic [KIND_W-1:0] {
    K_NOP     = 3'd0,
    K_WRITE   = 3'd1,
    K_INVALID = 3'd2,
    K_EDGE    = 3'd3,
    K_INTERP  = 3'd4
  } kind_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SCALE_MIN   = 2'd0,
    REG_SCALE_MAX   = 2'd1,
    REG_COLOR_COUNT = 2'd2
  } cfg_reg_t;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

endpackage
`default_nettype wire

// File: rtl/core/plcm_in_if.sv
// Input item channel: valid/ready plus write and lookup fields.
// Standalone; no package dependency.
`default_nettype none
interface plcm_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [7:0]  entry_index;
  logic [7:0]  entry_red;
  logic [7:0]  entry_green;
  logic [7:0]  entry_blue;
  logic [31:0] value;

  modport source (output valid, func, entry_index, entry_red, entry_green, entry_blue,
                  value, input ready);
  modport sink (input valid, func, entry_index, entry_red, entry_green, entry_blue,
                value, output ready);
endinterface
`default_nettype wire

// File: rtl/core/plcm_out_if.sv
// Result channel: valid/ready plus interpolated color.
// Standalone; no package dependency.
`default_nettype none
interface plcm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       color_valid;

  modport source (output valid, red, green, blue, color_valid, input ready);
  modport sink (input valid, red, green, blue, color_valid, output ready);
endinterface
`default_nettype wire

// File: rtl/core/plcm_cfg_if.sv
// Configuration write channel: valid/ready, register index and data.
// Standalone; no package dependency.
`default_nettype none
interface plcm_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/plcm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module plcm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: rtl/core/plcm_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a side tag.
// No package dependency.
`default_nettype none
module plcm_div #(
  parameter int QB = 24,
  parameter int TW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [31:0]   r_in,      // partial remainder, below divisor
  input  wire logic [QB-1:0] low_in,    // dividend bits still to shift in
  input  wire logic [31:0]   range_in,  // divisor
  input  wire logic [TW-1:0] tag_in,
  output logic      [QB-1:0] q_out,
  output logic      [TW-1:0] tag_out
);
  logic [31:0]   r_q   [1:QB];
  logic [QB-1:0] lq    [1:QB];
  logic [31:0]   rng_q [1:QB];
  logic [TW-1:0] tag_q [1:QB];

  for (genvar i = 0; i < QB; i++) begin : g_stage
    logic [31:0]   src_r;
    logic [QB-1:0] src_l;
    logic [31:0]   src_rng;
    logic [TW-1:0] src_tag;
    logic [32:0]   t;
    logic [32:0]   sub;
    logic          ge;

    if (i == 0) begin : g_first
      assign src_r   = r_in;
      assign src_l   = low_in;
      assign src_rng = range_in;
      assign src_tag = tag_in;
    end else begin : g_next
      assign src_r   = r_q[i];
      assign src_l   = lq[i];
      assign src_rng = rng_q[i];
      assign src_tag = tag_q[i];
    end

    assign t   = {src_r, src_l[QB-1]};
    assign ge  = t >= {1'b0, src_rng};
    assign sub = t - {1'b0, src_rng};

    always_ff @(posedge clk) begin
      if (rst) begin
        tag_q[i+1] <= '0;
      end else begin
        tag_q[i+1] <= src_tag;
      end
      r_q[i+1]   <= ge ? sub[31:0] : t[31:0];
      lq[i+1]    <= {src_l[QB-2:0], ge};
      rng_q[i+1] <= src_rng;
    end
  end

  assign q_out   = lq[QB];
  assign tag_out = tag_q[QB];
endmodule
`default_nettype wire

// File: rtl/core/plcm_out_fifo.sv
// Result FIFO in flip-flops; decouples the pipeline from output stalls.
// No package dependency.
`default_nettype none
module plcm_out_fifo #(
  parameter int DEPTH = 32,
  parameter int W     = 25
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] pdata,
  input  wire logic         pop,
  output logic              not_empty,
  output logic      [W-1:0] rdata
);
  localparam int AW = $clog2(DEPTH);

  logic [W-1:0] buf_q [DEPTH];
  logic [AW:0]  wptr;
  logic [AW:0]  rptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
    end
    if (push) buf_q[wptr[AW-1:0]] <= pdata;
  end

  assign not_empty = wptr != rptr;
  assign rdata     = buf_q[rptr[AW-1:0]];
endmodule
`default_nettype wire

// File: rtl/core/piecewise_linear_color_map.sv
// Piecewise-linear color map top level: front end, divider, table RAMs, blend, result FIFO.
// Depends on plcm_pkg, the three channel interfaces, plcm_ram, plcm_div, plcm_out_fifo.
//
// Accepts one item per cycle while input ready is high, writes and lookups alike, and
// delivers one result per lookup in order. A lookup passes stages A and B, then the
// divider that yields one quotient bit per stage for (value - scale_min) * (count - 1) /
// (scale_max - scale_min), then the table RAMs with stage C. Results queue in a FIFO
// deeper than that pipeline, so the input keeps flowing while results wait; input
// ready drops only once FIFO_DEPTH lookups are outstanding. Table writes travel
// down the same pipeline and land in the RAMs at the stage where lookups read, so
// every lookup sees exactly the writes before it. Table entries are undefined until
// written; there is no clearing pass. Config writes are taken every cycle and must
// only be issued while the block is idle.
`default_nettype none
module piecewise_linear_color_map
  import plcm_pkg::*;
#(
  parameter int TABLE_DEPTH   = 256,
  parameter int CHANNEL_BITS  = 8,
  parameter int FRACTION_BITS = 16
) (
  input wire logic  clk,
  input wire logic  rst,
  plcm_in_if.sink   inp,
  plcm_out_if.source res,
  plcm_cfg_if.sink  cfg
);
  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int NW  = $clog2(TABLE_DEPTH + 1);
  localparam int C   = CHANNEL_BITS;
  localparam int F   = FRACTION_BITS;
  localparam int QB  = AW + F;
  localparam int TW  = KIND_W + AW + 3 * C;
  localparam int LAT = QB + 4;
  localparam int FIFO_DEPTH = 2 ** $clog2(LAT + 2);
  localparam int PW  = $clog2(FIFO_DEPTH + 1);
  localparam int OW  = 25;

  // Config registers.
  logic signed [31:0] scale_min;
  logic signed [31:0] scale_max;
  logic [8:0]         color_count;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_min   <= '0;
      scale_max   <= '0;
      color_count <= '0;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_SCALE_MIN:   scale_min   <= cfg.data;
        REG_SCALE_MAX:   scale_max   <= cfg.data;
        REG_COLOR_COUNT: color_count <= cfg.data[8:0];
        default: ;
      endcase
    end
  end

  // Credit: lookups accepted but not yet delivered never exceed FIFO room.
  logic [PW-1:0] pending;
  logic          in_beat;
  logic          out_beat;
  logic          is_lookup;

  assign inp.ready = pending < PW'(FIFO_DEPTH);
  assign in_beat   = inp.valid & inp.ready;
  assign is_lookup = inp.func == FUNC_LOOKUP;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + PW'(in_beat & is_lookup) - PW'(out_beat);
    end
  end

  // Front end: classify the item, form difference and range.
  logic [31:0]        cnt_ext;
  logic [31:0]        n32;
  logic [NW-1:0]      n;
  logic [NW-1:0]      nm1_w;
  logic signed [32:0] d33;
  logic signed [32:0] r33;
  kind_t              kind_n;
  logic [AW-1:0]      addr_n;

  always_comb begin
    cnt_ext = 32'(color_count);
    n32     = (cnt_ext > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : cnt_ext;
    n       = n32[NW-1:0];
    nm1_w   = n - NW'(1);
    d33     = {inp.value[31], inp.value} - {scale_min[31], scale_min};
    r33     = {scale_max[31], scale_max} - {scale_min[31], scale_min};
    kind_n  = K_NOP;
    addr_n  = '0;
    if (in_beat) begin
      if (!is_lookup) begin
        addr_n = AW'(inp.entry_index);
        if (32'(inp.entry_index) < 32'(TABLE_DEPTH)) kind_n = K_WRITE;
      end else if (n < NW'(2)) begin
        kind_n = K_INVALID;
      end else if ($signed(inp.value) >= scale_max) begin
        kind_n = K_EDGE;
        addr_n = nm1_w[AW-1:0];
      end else if ($signed(inp.value) <= scale_min) begin
        kind_n = K_EDGE;
      end else begin
        kind_n = K_INTERP;
      end
    end
  end

  // Stage A.
  kind_t          kind_a;
  logic [AW-1:0]  addr_a;
  logic [3*C-1:0] wdata_a;
  logic [31:0]    diff_a;
  logic [31:0]    range_a;
  logic [AW-1:0]  nm1_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      kind_a <= K_NOP;
    end else begin
      kind_a <= kind_n;
    end
    addr_a  <= addr_n;
    wdata_a <= {C'(16'(inp.entry_red)), C'(16'(inp.entry_green)), C'(16'(inp.entry_blue))};
    diff_a  <= d33[31:0];
    range_a <= r33[31:0];
    nm1_a   <= nm1_w[AW-1:0];
  end

  // Stage B: scale the difference by the interval count.
  logic [32+AW-1:0] prod_b;
  logic [31:0]      range_b;
  logic [TW-1:0]    tag_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_b <= '0;
    end else begin
      tag_b <= {kind_a, addr_a, wdata_a};
    end
    prod_b  <= diff_a * nm1_a;
    range_b <= range_a;
  end

  // Quotient of (prod << F) / range: interval index above, fraction below.
  logic [QB-1:0] q_d;
  logic [TW-1:0] tag_d;

  plcm_div #(.QB(QB), .TW(TW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .r_in     (prod_b[32+AW-1:AW]),
    .low_in   ({prod_b[AW-1:0], F'(0)}),
    .range_in (range_b),
    .tag_in   (tag_b),
    .q_out    (q_d),
    .tag_out  (tag_d)
  );

  kind_t          kind_d;
  logic [AW-1:0]  addr_d;
  logic [3*C-1:0] wdata_d;
  logic [AW-1:0]  i0_d;
  logic [AW-1:0]  raddr0;
  logic [AW-1:0]  raddr1;
  logic           we;

  assign kind_d  = kind_t'(tag_d[TW-1 -: KIND_W]);
  assign addr_d  = tag_d[3*C +: AW];
  assign wdata_d = tag_d[3*C-1:0];
  assign i0_d    = q_d[QB-1:F];
  assign raddr0  = (kind_d == K_INTERP) ? i0_d : addr_d;
  assign raddr1  = i0_d + AW'(1);
  assign we      = kind_d == K_WRITE;

  // Two copies of the table so both neighbors are read in the same cycle.
  logic [3*C-1:0] c0_q;
  logic [3*C-1:0] c1_q;

  plcm_ram #(.WIDTH(3 * C), .DEPTH(TABLE_DEPTH)) u_ram0 (
    .clk (clk), .we (we), .waddr (addr_d), .wdata (wdata_d),
    .raddr (raddr0), .rdata (c0_q)
  );

  plcm_ram #(.WIDTH(3 * C), .DEPTH(TABLE_DEPTH)) u_ram1 (
    .clk (clk), .we (we), .waddr (addr_d), .wdata (wdata_d),
    .raddr (raddr1), .rdata (c1_q)
  );

  // Stage C: aligned with RAM read data.
  kind_t        kind_c;
  logic [F-1:0] frac_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      kind_c <= K_NOP;
    end else begin
      kind_c <= kind_d;
    end
    frac_c <= q_d[F-1:0];
  end

  // Blend, round to nearest with ties up.
  logic [F:0]     one_m;
  logic [7:0]     ch_out [3];
  logic [OW-1:0]  push_data;
  logic           push;

  assign one_m = {1'b1, F'(0)} - {1'b0, frac_c};

  for (genvar k = 0; k < 3; k++) begin : g_chan
    logic [C-1:0]     a;
    logic [C-1:0]     b;
    logic [C+F:0]     p0;
    logic [C+F:0]     p1;
    logic [C+F+1:0]   sum;
    logic [C-1:0]     mix;
    logic [15:0]      wide;

    assign a    = c0_q[(2-k)*C +: C];
    assign b    = c1_q[(2-k)*C +: C];
    assign p0   = a * one_m;
    assign p1   = b * {1'b0, frac_c};
    assign sum  = (C+F+2)'(p0) + (C+F+2)'(p1) + (C+F+2)'(1 << (F - 1));
    assign mix  = sum[F+C-1:F];
    assign wide = (kind_c == K_INTERP) ? 16'(mix)
                : (kind_c == K_EDGE)   ? 16'(a) : 16'(0);
    assign ch_out[k] = wide[7:0];
  end

  assign push = kind_c == K_INVALID || kind_c == K_EDGE || kind_c == K_INTERP;
  assign push_data = {kind_c != K_INVALID, ch_out[0], ch_out[1], ch_out[2]};

  logic          fifo_ne;
  logic [OW-1:0] fifo_q;

  plcm_out_fifo #(.DEPTH(FIFO_DEPTH), .W(OW)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pdata     (push_data),
    .pop       (out_beat),
    .not_empty (fifo_ne),
    .rdata     (fifo_q)
  );

  assign res.valid       = fifo_ne;
  assign out_beat        = fifo_ne & res.ready;
  assign res.color_valid = fifo_q[24];
  assign res.red         = fifo_q[23:16];
  assign res.green       = fifo_q[15:8];
  assign res.blue        = fifo_q[7:0];
endmodule
`default_nettype wire

// File: rtl/core/plcm_checker.sv
// Port-level checks on the result channel of the color map, bound to the top level.
// Depends on piecewise_linear_color_map port names only.
`default_nettype none
module plcm_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       valid,
  input wire logic       ready,
  input wire logic [7:0] red,
  input wire logic [7:0] green,
  input wire logic [7:0] blue,
  input wire logic       color_valid
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid)
    else $error("result beat dropped while stalled");

  a_stable: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> $stable({red, green, blue, color_valid}))
    else $error("stalled result changed");

  a_invalid_black: assert property (@(posedge clk) disable iff (rst)
    valid && !color_valid |-> red == 8'd0 && green == 8'd0 && blue == 8'd0)
    else $error("invalid color carries nonzero channels");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !valid)
    else $error("result present right after reset");
endmodule

bind piecewise_linear_color_map plcm_checker u_plcm_checker (
  .clk         (clk),
  .rst         (rst),
  .valid       (res.valid),
  .ready       (res.ready),
  .red         (res.red),
  .green       (res.green),
  .blue        (res.blue),
  .color_valid (res.color_valid)
);
`default_nettype wire
